### hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stuffed frame receiver and its checker.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0]  MARK_BYTE  = 8'hAA;
  localparam logic [7:0]  START_BYTE = 8'hCC;
  localparam logic [7:0]  END_BYTE   = 8'hEE;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_CRC_ERR  = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_RESTART  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT      = 4'b0001,
    PH_HUNT_MARK = 4'b0010,
    PH_DATA      = 4'b0100,
    PH_DATA_MARK = 4'b1000
  } phase_t;

endpackage

### hw/rtl/stuffed_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// A byte accepted into the input register has its result, if any, registered in the
// result register, which drives the outputs until the result is taken.
// Throughput: one byte per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when a result is not taken.
// Reset (rst, synchronous): the block hunts for a start mark with an empty
// count and the CRC at 0xFFFF; no result is pending.
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16
// Removes byte stuffing from a received serial stream, finds frames between
// the start and end marks, emits payload bytes and checks CRC-16/MODBUS.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_crc16
  import sfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data_byte,
  output logic [8:0] frame_length
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_FRAME_BYTES);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Frame state.
  phase_t        phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]   running_crc, running_crc_next;

  // Result of the current item.
  logic          res_valid;
  kind_t         res_kind;
  logic [7:0]    res_data;
  logic [CW-1:0] res_len;
  logic [CW+8:0] res_len_ext;
  logic [15:0]   crc_folded;
  logic [CW-1:0] count_inc;
  logic          advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  sfr_crc16 u_crc (
    .crc      (running_crc),
    .data     (s1_byte),
    .crc_next (crc_folded)
  );

  assign count_inc = byte_count + CW'(1);

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    res_valid        = 1'b0;
    res_kind         = KIND_PAYLOAD;
    res_data         = 8'h00;
    res_len          = byte_count;

    if (byte_count == COUNT_FULL) begin
      phase_next       = PH_HUNT;
      byte_count_next  = '0;
      running_crc_next = CRC_INIT;
      res_valid        = 1'b1;
      res_kind         = KIND_OVERFLOW;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (s1_byte == MARK_BYTE) begin
            phase_next = PH_HUNT_MARK;
          end
        end
        PH_HUNT_MARK: begin
          byte_count_next  = '0;
          running_crc_next = CRC_INIT;
          phase_next       = (s1_byte == START_BYTE) ? PH_DATA : PH_HUNT;
        end
        PH_DATA: begin
          if (s1_byte == MARK_BYTE) begin
            phase_next = PH_DATA_MARK;
          end else begin
            byte_count_next  = count_inc;
            running_crc_next = crc_folded;
            res_valid        = 1'b1;
            res_data         = s1_byte;
            res_len          = count_inc;
          end
        end
        PH_DATA_MARK: begin
          if (s1_byte == MARK_BYTE) begin
            // A doubled mark is one literal mark byte of payload.
            phase_next       = PH_DATA;
            byte_count_next  = count_inc;
            running_crc_next = crc_folded;
            res_valid        = 1'b1;
            res_data         = s1_byte;
            res_len          = count_inc;
          end else if (s1_byte == START_BYTE) begin
            phase_next       = PH_DATA;
            byte_count_next  = '0;
            running_crc_next = CRC_INIT;
            res_valid        = 1'b1;
            res_kind         = KIND_RESTART;
          end else if (s1_byte == END_BYTE) begin
            phase_next       = PH_HUNT;
            byte_count_next  = '0;
            running_crc_next = CRC_INIT;
            res_valid        = 1'b1;
            res_kind         = (running_crc == 16'h0000) ? KIND_GOOD : KIND_CRC_ERR;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Only the low nine bits of the count are shown.
  assign res_len_ext = {9'd0, res_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_crc <= CRC_INIT;
      out_valid   <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && res_valid;
      if (s1_valid) begin
        phase       <= phase_next;
        byte_count  <= byte_count_next;
        running_crc <= running_crc_next;
      end
    end
    if (advance && s1_valid && res_valid) begin
      kind         <= res_kind;
      data_byte    <= res_data;
      frame_length <= res_len_ext[8:0];
    end
  end

endmodule

### hw/rtl/sfr_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_crc16
// Folds one byte into a reflected CRC-16 (polynomial 0xA001), one bit per
// step over the eight bits of the byte.
// ----------------------------------------------------------------------------
module sfr_crc16
  import sfr_pkg::*;
(
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);

  always_comb begin
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_next = c;
  end

endmodule

### hw/rtl/sfr_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_check
// Port-level checks on the stuffed frame receiver, bound to its top level.
// ----------------------------------------------------------------------------
module sfr_check
  import sfr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] data_byte,
  input logic [8:0] frame_length
);

  // A request that is held off keeps its byte until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(rx_byte))
    else $error("request changed while held off");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(frame_length))
    else $error("result changed while stalled");

  // No result is pending straight after reset.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_PAYLOAD) || (kind == KIND_GOOD) || (kind == KIND_CRC_ERR)
      || (kind == KIND_OVERFLOW) || (kind == KIND_RESTART))
    else $error("illegal result kind");

  // Only payload results carry a data byte.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_PAYLOAD) |-> data_byte == 8'h00)
    else $error("data byte set on a status result");

endmodule

bind stuffed_frame_receiver_crc16 sfr_check u_sfr_check (.*);

### sim/stuffed_frame_receiver_crc16_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16_tb
// Feeds the frame receiver with stuffed frames (good, corrupted, restarted,
// overlong) and line noise under several handshake mixes. A tracker in the
// bench follows the framing and CRC state byte by byte and checks every
// report that the block returns.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_crc16_tb;
  import sfr_pkg::*;

  localparam int MAX_FRAME    = 256;
  localparam int RANDOM_BYTES = 1600;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG     = 4000;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [8:0] length;
  } report_t;

  // Follows the deframing state and keeps the reports that the block owes.
  class frame_tracker;
    phase_t      phase;
    int          count;
    logic [15:0] crc;
    report_t     expected_reports[$];
    int          failures;
    int          seen[5];

    function new();
      phase    = PH_HUNT;
      failures = 0;
      foreach (seen[i]) seen[i] = 0;
      restart_crc();
    endfunction

    static function logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    function void restart_crc();
      count = 0;
      crc   = CRC_INIT;
    endfunction

    function report_t take_payload(logic [7:0] b);
      count++;
      crc = crc16_fold(crc, b);
      return '{KIND_PAYLOAD, b, 9'(count)};
    endfunction

    function void note_rx_byte(logic [7:0] b);
      report_t r;
      bit      owed;
      owed = 1'b0;
      if (count >= MAX_FRAME) begin
        r     = '{KIND_OVERFLOW, 8'h00, 9'(count)};
        owed  = 1'b1;
        phase = PH_HUNT;
        restart_crc();
      end else begin
        case (phase)
          PH_HUNT: begin
            if (b == MARK_BYTE) phase = PH_HUNT_MARK;
          end
          PH_HUNT_MARK: begin
            restart_crc();
            if (b == START_BYTE) phase = PH_DATA;
            else phase = PH_HUNT;
          end
          PH_DATA: begin
            if (b == MARK_BYTE) begin
              phase = PH_DATA_MARK;
            end else begin
              r    = take_payload(b);
              owed = 1'b1;
            end
          end
          default: begin
            if (b == MARK_BYTE) begin
              phase = PH_DATA;
              r     = take_payload(b);
              owed  = 1'b1;
            end else if (b == START_BYTE) begin
              r     = '{KIND_RESTART, 8'h00, 9'(count)};
              owed  = 1'b1;
              phase = PH_DATA;
              restart_crc();
            end else if (b == END_BYTE) begin
              r     = '{(crc == 16'h0000) ? KIND_GOOD : KIND_CRC_ERR, 8'h00, 9'(count)};
              owed  = 1'b1;
              phase = PH_HUNT;
              restart_crc();
            end else begin
              // An unknown escape is dropped; the phase after the mark is kept for the next byte.
            end
          end
        endcase
      end
      if (owed) expected_reports.push_back(r);
    endfunction

    function void flag_mismatch(string what, report_t exp, report_t got);
      failures++;
      if (failures <= SHOWN_ERRORS) begin
        $display("MISMATCH (%s) at %0t: expected kind %0d data %02h len %0d",
                 what, $realtime, exp.kind, exp.data, exp.length);
        $display("  got kind %0d data %02h len %0d", got.kind, got.data, got.length);
      end
    endfunction

    function void check_result(report_t got);
      report_t exp;
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected", '0, got);
      end else begin
        exp = expected_reports.pop_front();
        if (got.kind !== exp.kind || got.data !== exp.data || got.length !== exp.length)
          flag_mismatch("field", exp, got);
        else
          seen[exp.kind]++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic [8:0] frame_length;

  frame_tracker book = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;
  bit hold_req       = 1'b0;

  stuffed_frame_receiver_crc16 #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_length (frame_length)
  );

  always #4 clk = ~clk;

  // Result side: random stalls, and a long hold-off whenever one is requested.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        book.check_result('{kind_t'(kind), data_byte, frame_length});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("Watchdog: no handshake for %0d cycles, %0d reports outstanding",
                 WATCHDOG, book.pending());
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] rand_payload();
    return ($urandom_range(0, 5) == 0) ? MARK_BYTE : 8'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    book.note_rx_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == MARK_BYTE) send_byte(MARK_BYTE);
    send_byte(b);
  endtask

  task automatic send_junk_escape();
    logic [7:0] j;
    do j = 8'($urandom); while (j == MARK_BYTE || j == START_BYTE || j == END_BYTE);
    send_byte(MARK_BYTE);
    send_byte(j);
  endtask

  // A complete frame: n payload bytes and their CRC, low byte first.
  task automatic send_frame(input int n, input bit corrupt, input bit junk);
    logic [7:0]  body[$];
    logic [15:0] c;
    int          junk_at;
    int          idx;
    c = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      body.push_back(rand_payload());
      c = frame_tracker::crc16_fold(c, body[i]);
    end
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    if (corrupt) begin
      idx = $urandom_range(0, body.size() - 1);
      body[idx] = body[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
    junk_at = junk ? $urandom_range(0, body.size()) : -1;
    send_byte(MARK_BYTE);
    send_byte(START_BYTE);
    foreach (body[i]) begin
      if (i == junk_at) send_junk_escape();
      send_stuffed(body[i]);
    end
    if (junk_at == body.size()) send_junk_escape();
    send_byte(MARK_BYTE);
    send_byte(END_BYTE);
  endtask

  // An opened frame left unfinished, so that the next start mark restarts it.
  task automatic send_opening(input int n);
    send_byte(MARK_BYTE);
    send_byte(START_BYTE);
    for (int i = 0; i < n; i++) send_stuffed(rand_payload());
  endtask

  task automatic random_burst();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      send_frame($urandom_range(0, 24), 1'b0, $urandom_range(0, 9) == 0);
    end else if (pick < 70) begin
      send_frame($urandom_range(0, 24), 1'b1, $urandom_range(0, 9) == 0);
    end else if (pick < 80) begin
      send_opening($urandom_range(0, 12));
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 6)) send_byte(rand_payload());
    end else if (pick < 99) begin
      send_byte(MARK_BYTE);
      send_byte(($urandom_range(0, 1) == 0) ? MARK_BYTE : END_BYTE);
    end else begin
      send_frame($urandom_range(250, 262), 1'b0, 1'b0);
    end
  endtask

  initial begin : stimulus
    int send_mix[4];
    int recv_mix[4];
    int target;
    send_mix = '{0, 68, 0, 37};
    recv_mix = '{0, 0, 68, 37};
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bad openings: a doubled mark and a stray byte after the mark.
    send_byte(MARK_BYTE);
    send_byte(MARK_BYTE);
    send_byte(MARK_BYTE);
    send_byte(8'h55);
    // Payload extremes, with a stuffed mark in the middle.
    send_byte(MARK_BYTE);
    send_byte(START_BYTE);
    send_stuffed(8'h00);
    send_stuffed(MARK_BYTE);
    send_stuffed(8'hFF);
    send_stuffed(8'h3F);
    send_stuffed(8'h95);
    send_byte(MARK_BYTE);
    send_byte(END_BYTE);
    // Unknown escape inside an opened frame; the next frame's opening mark then reads as a doubled mark.
    send_byte(MARK_BYTE);
    send_byte(START_BYTE);
    send_byte(8'h12);
    send_byte(MARK_BYTE);
    send_byte(8'h33);
    send_frame(1, 1'b0, 1'b0);
    send_frame(1, 1'b1, 1'b0);
    // Count full: the byte after the 256th payload byte overflows.
    send_frame(MAX_FRAME, 1'b0, 1'b0);

    // The result side holds off while a long frame keeps arriving.
    hold_req = 1'b1;
    send_frame(40, 1'b0, 1'b0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_mix[p];
      recv_stall_pct = recv_mix[p];
      target = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) random_burst();
    end
    in_valid       <= 1'b0;
    recv_stall_pct = 0;

    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (book.pending() != 0) begin
      book.failures++;
      $display("%0d expected reports never arrived", book.pending());
    end
    if (book.failures > SHOWN_ERRORS)
      $display("%0d further mismatches not shown", book.failures - SHOWN_ERRORS);
    $display("Run covered %0d serial bytes under four handshake mixes and one long hold-off.",
             bytes_sent);
    $display("Checked %0d data, %0d good, %0d CRC error, %0d overflow, %0d restart reports.",
             book.seen[KIND_PAYLOAD], book.seen[KIND_GOOD], book.seen[KIND_CRC_ERR],
             book.seen[KIND_OVERFLOW], book.seen[KIND_RESTART]);
    if (book.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_crc16.sv
hw/rtl/stuffed_frame_receiver_crc16.sv
hw/rtl/sfr_check.sv
sim/stuffed_frame_receiver_crc16_tb.sv
